/* src/sbw_pkg.sv */
// ----------------------------------------------------------------------------
// sbw_pkg
// Shared types and command codes for the stuffed bit writer.
// ----------------------------------------------------------------------------
package sbw_pkg;

	// command codes carried in the func field
	localparam logic [2:0] FUNC_ZERO   = 3'd0;
	localparam logic [2:0] FUNC_ONE    = 3'd1;
	localparam logic [2:0] FUNC_FLUSH0 = 3'd2;
	localparam logic [2:0] FUNC_FLUSH1 = 3'd3;
	localparam logic [2:0] FUNC_BYTE   = 3'd4;
	localparam logic [2:0] FUNC_SHORT  = 3'd5;
	localparam logic [2:0] FUNC_INT    = 3'd6;

	// byte values with special meaning in the stream
	localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;
	localparam logic [7:0] BYTE_STUFFED  = 8'h7F;

	// most results one item can cause
	localparam int unsigned MAX_RESULTS = 4;

	typedef logic [2:0] count_t;
	typedef logic [1:0] index_t;

	// input transaction payload
	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] data_value;
	} sbw_in_t;

	// output transaction payload
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
		logic       align_error;
	} sbw_out_t;

	// all results of one item, first byte in slot 0
	typedef struct packed {
		count_t                          count;
		logic [MAX_RESULTS-1:0][7:0]     bytes;
		logic                            err;
	} sbw_burst_t;

endpackage

/* src/sbw_encode.sv */
// ----------------------------------------------------------------------------
// sbw_encode
// Bit packing state and the single-pass logic that turns one command into
// its burst of stream bytes.
// ----------------------------------------------------------------------------
module sbw_encode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  sbw_pkg::sbw_in_t   item,
	output sbw_pkg::sbw_burst_t burst
);
	import sbw_pkg::*;

	logic [7:0] partial_q;
	logic [2:0] pos_q;
	logic [7:0] partial_d;
	logic [2:0] pos_d;
	logic [7:0] bit_byte;
	logic [7:0] ones_byte;
	logic       bit_in;

	// candidate bytes for bit append and ones flush
	assign bit_in    = (item.func == FUNC_ONE);
	assign bit_byte  = partial_q | (bit_in ? (8'h80 >> pos_q) : BYTE_ZERO);
	assign ones_byte = partial_q | (BYTE_ALL_ONES >> pos_q);

	// command decode
	always_comb begin
		partial_d   = partial_q;
		pos_d       = pos_q;
		burst.count = 3'd0;
		burst.bytes = '0;
		burst.err   = 1'b0;
		case (item.func)
			FUNC_ZERO, FUNC_ONE: begin
				if (pos_q == 3'd7) begin
					burst.count    = 3'd1;
					burst.bytes[0] = bit_byte;
					pos_d          = (bit_byte == BYTE_ALL_ONES) ? 3'd1 : 3'd0;
					partial_d      = BYTE_ZERO;
				end else begin
					partial_d = bit_byte;
					pos_d     = pos_q + 3'd1;
				end
			end
			FUNC_FLUSH0: begin
				if (pos_q != 3'd0) begin
					burst.count    = 3'd1;
					burst.bytes[0] = partial_q;
				end
				pos_d     = 3'd0;
				partial_d = BYTE_ZERO;
			end
			FUNC_FLUSH1: begin
				if (pos_q != 3'd0) begin
					burst.bytes[0] = ones_byte;
					// completed 0xff forces a filled stuffed byte after it
					if (ones_byte == BYTE_ALL_ONES) begin
						burst.count    = 3'd2;
						burst.bytes[1] = BYTE_STUFFED;
					end else begin
						burst.count = 3'd1;
					end
				end
				pos_d     = 3'd0;
				partial_d = BYTE_ZERO;
			end
			FUNC_BYTE, FUNC_SHORT, FUNC_INT: begin
				if (pos_q != 3'd0) begin
					// misaligned write: one error result, state kept
					burst.count = 3'd1;
					burst.err   = 1'b1;
				end else if (item.func == FUNC_BYTE) begin
					burst.count    = 3'd1;
					burst.bytes[0] = item.data_value[7:0];
				end else if (item.func == FUNC_SHORT) begin
					burst.count    = 3'd2;
					burst.bytes[0] = item.data_value[15:8];
					burst.bytes[1] = item.data_value[7:0];
				end else begin
					burst.count    = 3'd4;
					burst.bytes[0] = item.data_value[31:24];
					burst.bytes[1] = item.data_value[23:16];
					burst.bytes[2] = item.data_value[15:8];
					burst.bytes[3] = item.data_value[7:0];
				end
			end
			default: begin
			end
		endcase
	end

	// packing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= BYTE_ZERO;
			pos_q     <= 3'd0;
		end else if (take) begin
			partial_q <= partial_d;
			pos_q     <= pos_d;
		end
	end

`ifndef ASSERT_OFF
	// nothing pending means the partial byte is empty
	a_empty_partial: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == 3'd0) |-> (partial_q == BYTE_ZERO))
		else $error("partial byte holds bits with no position pending");

	// any flush leaves the writer aligned
	a_flush_aligns: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (item.func == FUNC_FLUSH0 || item.func == FUNC_FLUSH1))
		|=> (pos_q == 3'd0))
		else $error("flush did not align the writer");

	// an error burst is a single result
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		burst.err |-> (burst.count == 3'd1 && pos_q != 3'd0))
		else $error("error burst malformed");
`endif

endmodule

/* src/sbw_drain.sv */
// ----------------------------------------------------------------------------
// sbw_drain
// Result register holding one burst and handing its bytes out one
// transaction at a time.
// ----------------------------------------------------------------------------
module sbw_drain (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  sbw_pkg::sbw_burst_t burst,
	output logic                can_load,
	output logic                result_valid,
	input  logic                result_ready,
	output sbw_pkg::sbw_out_t   result
);
	import sbw_pkg::*;

	logic [MAX_RESULTS-1:0][7:0] bytes_s2;
	count_t                      count_s2;
	logic                        err_s2;
	logic                        valid_s2;
	index_t                      idx_q;
	logic                        is_last;
	logic                        out_take;

	// current byte and its position in the burst
	assign is_last  = ({1'b0, idx_q} == (count_s2 - 3'd1));
	assign out_take = valid_s2 && result_ready;
	assign can_load = !valid_s2 || (out_take && is_last);

	assign result_valid       = valid_s2;
	assign result.out_byte    = bytes_s2[idx_q];
	assign result.last_byte   = is_last;
	assign result.align_error = err_s2;

	// burst payload
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2 <= burst.bytes;
			count_s2 <= burst.count;
			err_s2   <= burst.err;
		end
	end

	// occupancy and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s2 <= (burst.count != 3'd0);
			idx_q    <= '0;
		end else if (out_take) begin
			if (is_last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

`ifndef ASSERT_OFF
	// a held burst has between one and four bytes
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (count_s2 != 3'd0 && count_s2 <= 3'd4))
		else $error("held burst has bad byte count");

	// the index never runs past the burst
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ({1'b0, idx_q} < count_s2))
		else $error("byte index past end of burst");

	// an error result is a lone zero byte
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && err_s2) |-> (is_last && result.out_byte == BYTE_ZERO))
		else $error("error result malformed");
`endif

endmodule

/* src/stuffed_bit_writer.sv */
// ----------------------------------------------------------------------------
// stuffed_bit_writer
// Bit-stuffing byte packer: single bits, flushes and aligned big-endian writes.
// ----------------------------------------------------------------------------
// A command transaction lands in an input register; when the result register
// can load, its whole burst of bytes (zero to four) is computed in one pass and
// loaded into the result register, which hands out one byte per output
// transaction, the final one flagged by last_byte. Commands that yield at most
// one byte, such as bit appends, stream at one per clock while the output is
// not stalled; a command yielding k bytes holds the result register for k
// output transactions, which sets the rate for word writes and ones flushes.
// Commands that yield nothing still pass through and update the packing state.
// The first byte is offered from the result register once the command has
// moved on from the input register.
module stuffed_bit_writer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  sbw_pkg::sbw_in_t  item,
	output logic              result_valid,
	input  logic              result_ready,
	output sbw_pkg::sbw_out_t result
);
	import sbw_pkg::*;

	sbw_in_t    item_s1;
	logic       valid_s1;
	logic       can_load;
	logic       move;
	sbw_burst_t burst;

	// input register advances when the result register frees up
	assign move       = valid_s1 && can_load;
	assign item_ready = !valid_s1 || can_load;

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	// command to burst
	sbw_encode u_encode (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (move),
		.item   (item_s1),
		.burst  (burst)
	);

	// burst to output transactions
	sbw_drain u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (move),
		.burst        (burst),
		.can_load     (can_load),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
